FILE: rtl/core/sspr_pkg.sv
// ----------------------------------------------------------------------------
// sspr_pkg
// Shared types and constants for the soft start period ramp: field widths,
// opcodes, configuration register indexes, reset values and beat structs.
// ----------------------------------------------------------------------------
package sspr_pkg;

    // field widths
    localparam int PERIOD_W = 16;
    localparam int HALF_W   = 15;
    localparam int VOUT_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // opcodes of an input beat
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_OFFSET = 3'd5;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] START_PERIOD_RST   = 16'd18133;
    localparam logic [PERIOD_W-1:0] TARGET_PERIOD_RST  = 16'd39100;
    localparam logic [PERIOD_W-1:0] RAMP_STEP_RST      = 16'd16;
    localparam logic [PERIOD_W-1:0] SKIP_COUNT_RST     = 16'd4;
    localparam logic [VOUT_W-1:0]   EXIT_THRESHOLD_RST = 12'd2048;
    localparam logic [PERIOD_W-1:0] COMPARE_OFFSET_RST = 16'd342;

    // off compare floor when the period is not above the offset
    localparam logic [PERIOD_W-1:0] OFF_COMPARE_MIN = 16'd1;

    typedef struct packed {
        logic [PERIOD_W-1:0] start_period;
        logic [PERIOD_W-1:0] target_period;
        logic [PERIOD_W-1:0] ramp_step;
        logic [PERIOD_W-1:0] skip_count;
        logic [VOUT_W-1:0]   exit_threshold;
        logic [PERIOD_W-1:0] compare_offset;
    } t_cfg;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_out;
        logic [HALF_W-1:0]   half_period;
        logic [PERIOD_W-1:0] off_compare;
        logic                period_written;
        logic                ramp_done;
        logic [PERIOD_W-1:0] frozen_period;
    } t_result;

endpackage

FILE: rtl/core/sspr_in_if.sv
// ----------------------------------------------------------------------------
// sspr_in_if
// Input channel: valid/ready handshake carrying an opcode and a voltage code.
// ----------------------------------------------------------------------------
interface sspr_in_if
    import sspr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [VOUT_W-1:0] vout_sample;

    modport source (output valid, output opcode, output vout_sample, input ready);
    modport sink   (input valid, input opcode, input vout_sample, output ready);
endinterface

FILE: rtl/core/sspr_out_if.sv
// ----------------------------------------------------------------------------
// sspr_out_if
// Result channel: valid/ready handshake carrying the period results.
// ----------------------------------------------------------------------------
interface sspr_out_if
    import sspr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_out;
    logic [HALF_W-1:0]   half_period;
    logic [PERIOD_W-1:0] off_compare;
    logic                period_written;
    logic                ramp_done;
    logic [PERIOD_W-1:0] frozen_period;

    modport source (
        output valid, output period_out, output half_period, output off_compare,
        output period_written, output ramp_done, output frozen_period, input ready
    );
    modport sink (
        input valid, input period_out, input half_period, input off_compare,
        input period_written, input ramp_done, input frozen_period, output ready
    );
endinterface

FILE: rtl/core/sspr_ramp.sv
// ----------------------------------------------------------------------------
// sspr_ramp
// Ramp state (period, prescale count, done flag, frozen period) and the
// next-state logic for one beat; also forms the result of that beat.
// ----------------------------------------------------------------------------
module sspr_ramp
    import sspr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic              i_opcode,
    input  logic [VOUT_W-1:0] i_vout_sample,
    output t_result           o_result
);

    logic [PERIOD_W-1:0] r_period, n_period;
    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic                r_done, n_done;
    logic [PERIOD_W-1:0] r_frozen, n_frozen;
    logic                written;
    logic [PERIOD_W:0]   sum;
    logic [PERIOD_W-1:0] tick_inc;
    logic                early_exit;

    assign sum        = {1'b0, r_period} + {1'b0, i_cfg.ramp_step};
    assign tick_inc   = r_tick + 1'b1;
    assign early_exit = i_vout_sample > i_cfg.exit_threshold;

    // next state for the beat on the input
    always_comb begin
        n_period = r_period;
        n_tick   = r_tick;
        n_done   = r_done;
        n_frozen = r_frozen;
        written  = 1'b0;
        if (i_opcode == OP_RESTART) begin
            n_period = i_cfg.start_period;
            n_done   = 1'b0;
            written  = 1'b1;
        end else if (!r_done) begin
            if (early_exit) begin
                n_done   = 1'b1;
                n_tick   = '0;
                n_frozen = r_period;
            end else if (tick_inc >= i_cfg.skip_count) begin
                n_tick  = '0;
                written = 1'b1;
                if (sum >= {1'b0, i_cfg.target_period}) begin
                    n_period = i_cfg.target_period;
                    n_done   = 1'b1;
                end else begin
                    n_period = sum[PERIOD_W-1:0];
                end
            end else begin
                n_tick = tick_inc;
            end
        end
    end

    // result fields of the beat
    always_comb begin
        o_result.period_out     = n_period;
        o_result.half_period    = n_period[PERIOD_W-1:1];
        o_result.off_compare    = (n_period > i_cfg.compare_offset) ?
                                  (n_period - i_cfg.compare_offset) : OFF_COMPARE_MIN;
        o_result.period_written = written;
        o_result.ramp_done      = n_done;
        o_result.frozen_period  = n_frozen;
    end

    // state update on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= START_PERIOD_RST;
            r_tick   <= '0;
            r_done   <= 1'b0;
            r_frozen <= '0;
        end else if (i_accept) begin
            r_period <= n_period;
            r_tick   <= n_tick;
            r_done   <= n_done;
            r_frozen <= n_frozen;
        end
    end

    // a restart always reopens the ramp
    a_restart_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_opcode == OP_RESTART)
        |=> !r_done && (r_period == $past(i_cfg.start_period)))
        else $error("restart did not reload the period");

    // early exit freezes the period and clears the prescaler
    a_exit_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_opcode == OP_TICK) && !r_done && early_exit
        |=> r_done && (r_tick == '0) && (r_frozen == $past(r_period)))
        else $error("early exit did not freeze the period");

    // once done, ticks leave the state alone
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_opcode == OP_TICK) && r_done
        |=> r_done && $stable(r_period) && $stable(r_tick) && $stable(r_frozen))
        else $error("tick changed state after the ramp finished");

endmodule

FILE: rtl/core/soft_start_period_ramp.sv
// A result is registered and appears on the output in the cycle after its input beat.
// Throughput: one beat per cycle; a new beat is taken whenever the result
// register is empty or is being emptied in the same cycle.
// The period state and result register are updated by one add, compare and
// clamp per beat. Synchronous active-low reset restores all configuration
// registers to their defaults, the period to the start value, and empties the output.
// ----------------------------------------------------------------------------
// soft_start_period_ramp
// Soft start switching period ramp with early exit on output voltage,
// configuration registers and a registered result channel.
// ----------------------------------------------------------------------------
module soft_start_period_ramp
    import sspr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sspr_in_if.sink               i_in,
    sspr_out_if.source            o_out
);

    t_cfg    r_cfg;
    t_result step_result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_period   <= START_PERIOD_RST;
            r_cfg.target_period  <= TARGET_PERIOD_RST;
            r_cfg.ramp_step      <= RAMP_STEP_RST;
            r_cfg.skip_count     <= SKIP_COUNT_RST;
            r_cfg.exit_threshold <= EXIT_THRESHOLD_RST;
            r_cfg.compare_offset <= COMPARE_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_PERIOD:   r_cfg.start_period   <= i_cfg_data;
                CFG_TARGET_PERIOD:  r_cfg.target_period  <= i_cfg_data;
                CFG_RAMP_STEP:      r_cfg.ramp_step      <= i_cfg_data;
                CFG_SKIP_COUNT:     r_cfg.skip_count     <= i_cfg_data;
                CFG_EXIT_THRESHOLD: r_cfg.exit_threshold <= i_cfg_data[VOUT_W-1:0];
                CFG_COMPARE_OFFSET: r_cfg.compare_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // take a beat when the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    sspr_ramp u_ramp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_opcode      (i_in.opcode),
        .i_vout_sample (i_in.vout_sample),
        .o_result      (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= step_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.period_out     = r_result.period_out;
    assign o_out.half_period    = r_result.half_period;
    assign o_out.off_compare    = r_result.off_compare;
    assign o_out.period_written = r_result.period_written;
    assign o_out.ramp_done      = r_result.ramp_done;
    assign o_out.frozen_period  = r_result.frozen_period;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !accept)
        else $error("input taken while result stalled");

    // every accepted beat shows up as a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid && (r_result == $past(step_result)))
        else $error("accepted beat did not reach the result register");

    // off compare never falls below its floor
    a_off_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.off_compare != '0))
        else $error("off compare reached zero");

endmodule

FILE: dv/sspr_ramp_checker.sv
// ----------------------------------------------------------------------------
// sspr_ramp_checker
// Watches the configuration port and both channels of the soft start period
// ramp, keeps its own copy of the ramp state and registers, works out the
// result of every accepted input beat and compares each result beat against
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module sspr_ramp_checker
    import sspr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sspr_in_if                    i_in,
    sspr_out_if                   i_out,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow registers and ramp state
    t_cfg                ramp_cfg;
    logic [PERIOD_W-1:0] period_q;
    logic [PERIOD_W-1:0] tick_q;
    logic [PERIOD_W-1:0] frozen_q;
    logic                done_q;

    // predicted result beats, oldest first
    t_result             period_results_q[$];

    // one field compare, counted on mismatch
    task automatic check_field(input string name, input logic [PERIOD_W-1:0] want,
                               input logic [PERIOD_W-1:0] seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            o_fail_count++;
        end
    endtask

    // advance the ramp by one input beat and form its result
    task automatic step_ramp(input logic op, input logic [VOUT_W-1:0] sample,
                             output t_result res);
        logic [PERIOD_W:0] sum;
        logic              written;
        written = 1'b0;
        sum     = '0;
        if (op == OP_RESTART) begin
            period_q = ramp_cfg.start_period;
            done_q   = 1'b0;
            written  = 1'b1;
        end else if (!done_q) begin
            if (sample > ramp_cfg.exit_threshold) begin
                // early exit on voltage, period frozen where it stands
                done_q   = 1'b1;
                tick_q   = '0;
                frozen_q = period_q;
            end else begin
                tick_q = tick_q + 1'b1;
                if (tick_q >= ramp_cfg.skip_count) begin
                    // carry kept so a wrapped sum still saturates
                    sum    = {1'b0, period_q} + {1'b0, ramp_cfg.ramp_step};
                    tick_q = '0;
                    if (sum >= {1'b0, ramp_cfg.target_period}) begin
                        period_q = ramp_cfg.target_period;
                        done_q   = 1'b1;
                    end else begin
                        period_q = sum[PERIOD_W-1:0];
                    end
                    written = 1'b1;
                end
            end
        end
        res.period_out     = period_q;
        res.half_period    = period_q[PERIOD_W-1:1];
        res.off_compare    = (period_q > ramp_cfg.compare_offset) ?
                             period_q - ramp_cfg.compare_offset : OFF_COMPARE_MIN;
        res.period_written = written;
        res.ramp_done      = done_q;
        res.frozen_period  = frozen_q;
    endtask

    // everything sampled at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        t_result fresh;
        if (!i_rst_n) begin
            ramp_cfg.start_period   = START_PERIOD_RST;
            ramp_cfg.target_period  = TARGET_PERIOD_RST;
            ramp_cfg.ramp_step      = RAMP_STEP_RST;
            ramp_cfg.skip_count     = SKIP_COUNT_RST;
            ramp_cfg.exit_threshold = EXIT_THRESHOLD_RST;
            ramp_cfg.compare_offset = COMPARE_OFFSET_RST;
            period_q     = START_PERIOD_RST;
            tick_q       = '0;
            frozen_q     = '0;
            done_q       = 1'b0;
            o_fail_count = 0;
            period_results_q.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                seen.period_out     = i_out.period_out;
                seen.half_period    = i_out.half_period;
                seen.off_compare    = i_out.off_compare;
                seen.period_written = i_out.period_written;
                seen.ramp_done      = i_out.ramp_done;
                seen.frozen_period  = i_out.frozen_period;
                if (period_results_q.size() == 0) begin
                    $error("result beat with no prediction outstanding");
                    o_fail_count++;
                end else begin
                    want = period_results_q.pop_front();
                    check_field("period_out", want.period_out, seen.period_out);
                    check_field("half_period", PERIOD_W'(want.half_period),
                                PERIOD_W'(seen.half_period));
                    check_field("off_compare", want.off_compare, seen.off_compare);
                    check_field("period_written", PERIOD_W'(want.period_written),
                                PERIOD_W'(seen.period_written));
                    check_field("ramp_done", PERIOD_W'(want.ramp_done),
                                PERIOD_W'(seen.ramp_done));
                    check_field("frozen_period", want.frozen_period,
                                seen.frozen_period);
                end
            end
            // input beat
            if (i_in.valid && i_in.ready) begin
                step_ramp(i_in.opcode, i_in.vout_sample, fresh);
                period_results_q.push_back(fresh);
            end
            // register write, unknown indexes dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_PERIOD:   ramp_cfg.start_period   = i_cfg_data;
                    CFG_TARGET_PERIOD:  ramp_cfg.target_period  = i_cfg_data;
                    CFG_RAMP_STEP:      ramp_cfg.ramp_step      = i_cfg_data;
                    CFG_SKIP_COUNT:     ramp_cfg.skip_count     = i_cfg_data;
                    CFG_EXIT_THRESHOLD: ramp_cfg.exit_threshold = i_cfg_data[VOUT_W-1:0];
                    CFG_COMPARE_OFFSET: ramp_cfg.compare_offset = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = period_results_q.size();
    end

endmodule

FILE: dv/tb_soft_start_period_ramp.sv
// ----------------------------------------------------------------------------
// tb_soft_start_period_ramp
// Stimulus for the soft start period ramp: a directed run over the corner
// cases of the ramp and its registers, then random phases under changing
// register settings with random idling on both channels, a long result
// hold-off and drain pauses. The checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_soft_start_period_ramp;
    import sspr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES      = 6;
    localparam int BEATS_PER_PHASE = 105;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 3;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    quiet_cycles;
    bit                    stalls_on    = 1'b1;
    bit                    hold_off_req = 1'b0;
    t_cfg                  setup;

    sspr_in_if  in_ch ();
    sspr_out_if out_ch ();

    soft_start_period_ramp dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    sspr_ramp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // no progress on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // offer one beat from a falling edge, return on the falling edge after it is taken
    task automatic send_beat(input logic op, input logic [VOUT_W-1:0] sample);
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.vout_sample <= sample;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // random gap on the input side
    task automatic maybe_idle();
        if (stalls_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // stop offering and let every outstanding result come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one register write; the caller lowers the enable after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // full register set, threshold written with junk in the unused top bits
    task automatic load_setup(input t_cfg c);
        write_reg(CFG_START_PERIOD, c.start_period);
        write_reg(CFG_TARGET_PERIOD, c.target_period);
        write_reg(CFG_RAMP_STEP, c.ramp_step);
        write_reg(CFG_SKIP_COUNT, c.skip_count);
        write_reg(CFG_EXIT_THRESHOLD, {4'($urandom), c.exit_threshold});
        write_reg(CFG_COMPARE_OFFSET, c.compare_offset);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // settings biased so the ramp mostly gets somewhere before a restart
    function automatic t_cfg random_setup();
        t_cfg c;
        c.start_period   = 16'($urandom_range(0, 40000));
        c.target_period  = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                           16'(c.start_period + $urandom_range(0, 3000));
        c.ramp_step      = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                           16'($urandom_range(1, 600));
        c.skip_count     = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(6, 65535)) :
                           16'($urandom_range(0, 5));
        c.exit_threshold = ($urandom_range(0, 2) == 0) ? 12'($urandom) :
                           12'($urandom_range(3000, 4095));
        c.compare_offset = 16'($urandom);
        return c;
    endfunction

    // random beat: mostly ticks at or below threshold, rare restarts and exits
    task automatic send_random_beat(input t_cfg c);
        logic              op;
        logic [VOUT_W-1:0] sample;
        op     = ($urandom_range(0, 39) == 0) ? OP_RESTART : OP_TICK;
        sample = ($urandom_range(0, 9) != 0) ? 12'($urandom_range(0, c.exit_threshold)) :
                 12'($urandom);
        send_beat(op, sample);
        maybe_idle();
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_RESTART;
        in_ch.vout_sample = '0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        rst_n             = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: advance on the fourth tick, sample at threshold stays in
        send_beat(OP_RESTART, 12'hFFF);
        repeat (4) send_beat(OP_TICK, 12'd2048);
        // just above threshold ends early, then a tick after done changes nothing
        send_beat(OP_TICK, 12'd2049);
        send_beat(OP_TICK, 12'd0);
        send_beat(OP_RESTART, 12'd0);
        send_beat(OP_TICK, 12'hFFF);

        // everything at its top: sum carries out, saturates, off compare floored
        wait_drained();
        setup = '{start_period: 16'hFFFF, target_period: 16'hFFFF, ramp_step: 16'hFFFF,
                  skip_count: 16'd0, exit_threshold: 12'hFFF, compare_offset: 16'hFFFF};
        load_setup(setup);
        send_beat(OP_RESTART, 12'd0);
        send_beat(OP_TICK, 12'hFFF);
        send_beat(OP_TICK, 12'd0);

        // start above target, zero threshold and offset
        wait_drained();
        setup = '{start_period: 16'd60000, target_period: 16'd1000, ramp_step: 16'd5,
                  skip_count: 16'd1, exit_threshold: 12'd0, compare_offset: 16'd0};
        load_setup(setup);
        send_beat(OP_RESTART, 12'd0);
        send_beat(OP_TICK, 12'd0);
        send_beat(OP_RESTART, 12'd0);
        send_beat(OP_TICK, 12'd1);

        // all zeros, then writes to unused indexes that must be dropped
        wait_drained();
        setup = '{start_period: 16'd0, target_period: 16'd0, ramp_step: 16'd0,
                  skip_count: 16'd0, exit_threshold: 12'd0, compare_offset: 16'd0};
        load_setup(setup);
        write_reg(CFG_IDX_W'(6), 16'hFFFF);
        write_reg(CFG_IDX_W'(7), 16'hFFFF);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_beat(OP_RESTART, 12'hAAA);
        send_beat(OP_TICK, 12'd0);
        send_beat(OP_TICK, 12'h555);

        // random phases, new settings each time the block is drained
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            setup = random_setup();
            load_setup(setup);
            if (phase == NUM_PHASES - 1) begin
                stalls_on = 1'b0;
            end
            // long hold-off on results while beats keep coming
            if (phase == 0) begin
                hold_off_req = 1'b1;
            end
            send_beat(OP_RESTART, 12'($urandom));
            for (int n = 1; n < BEATS_PER_PHASE; n++) begin
                send_random_beat(setup);
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
